@@ rtl/joystick_filter_deadband_pwm_macros.svh @@
// Assertion macros used by the joystick conditioner top level.
`ifndef JOYSTICK_FILTER_DEADBAND_PWM_MACROS_SVH
`define JOYSTICK_FILTER_DEADBAND_PWM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JFDP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JFDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jfdp_pkg.sv @@
// Types, widths, reset values and helpers of the joystick conditioner.
package jfdp_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int FRAC_BITS    = 8;
  localparam int Y_W          = SAMPLE_BITS + FRAC_BITS;
  localparam int ALPHA_W      = 9;
  localparam int WEIGHT_SHIFT = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << WEIGHT_SHIFT);
  localparam int EDGE_W       = 12;
  localparam int GAIN_W       = 16;
  localparam int GAIN_SHIFT   = 8;
  localparam int OUT_W        = 16;
  localparam int FILT_OUT_W   = 12;
  localparam int ZONE_W       = 2;
  localparam int DIST_W       = (SAMPLE_BITS > EDGE_W) ? SAMPLE_BITS : EDGE_W;
  localparam int D_W          = Y_W + 1;
  localparam int MCAND_W      = (D_W > GAIN_W + 1) ? D_W : GAIN_W + 1;
  localparam int MPLR_W       = (DIST_W > ALPHA_W) ? DIST_W : ALPHA_W;
  localparam int PROD_W       = MCAND_W + MPLR_W;
  localparam int CNT_W        = $clog2(MPLR_W);
  localparam int MAP_W        = GAIN_W + DIST_W - GAIN_SHIFT;
  localparam int SUM_W        = ((MAP_W > OUT_W) ? MAP_W : OUT_W) + 1;
  localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = FILT_OUT_W + ZONE_W + 3 * OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RST   = ALPHA_W'(26);
  localparam logic [EDGE_W-1:0]  START_RST   = EDGE_W'(2048);
  localparam logic [EDGE_W-1:0]  UPPER_RST   = EDGE_W'(2148);
  localparam logic [EDGE_W-1:0]  LOWER_RST   = EDGE_W'(1948);
  localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(256);
  localparam logic [OUT_W-1:0]   OUT_MIN_RST = OUT_W'(0);
  localparam logic [OUT_W-1:0]   OUT_MAX_RST = OUT_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA        = 3'd0,
    REG_FILTER_START = 3'd1,
    REG_UPPER_EDGE   = 3'd2,
    REG_LOWER_EDGE   = 3'd3,
    REG_GAIN         = 3'd4,
    REG_OUT_MIN      = 3'd5,
    REG_OUT_MAX      = 3'd6
  } cfg_reg_e;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_IN    = 2'd0,
    ZONE_ABOVE = 2'd1,
    ZONE_BELOW = 2'd2
  } zone_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_UPD,
    ST_ZONE,
    ST_MAP,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]  mplr;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  // Filter state loaded from a start value, truncated to the sample width.
  function automatic logic [Y_W-1:0] start_to_filter(input logic [EDGE_W-1:0] fs);
    logic [DIST_W-1:0] fs_ext;
    fs_ext = DIST_W'(fs);
    return {fs_ext[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
  endfunction

endpackage

@@ rtl/jfdp_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, signed multiplicand, unsigned multiplier.
module jfdp_serial_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jfdp_pkg::mul_req_t req_i,
  output jfdp_pkg::mul_rsp_t rsp_o
);
  import jfdp_pkg::*;

  logic [PROD_W-1:0]  acc_q, acc_d, addend;
  logic [MCAND_W-1:0] mcand_q;
  logic [MPLR_W-1:0]  mplr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;

  // One multiplier bit per cycle, most significant bit first.
  always_comb begin
    addend = mplr_q[MPLR_W-1] ? PROD_W'($signed(mcand_q)) : '0;
    acc_d  = {acc_q[PROD_W-2:0], 1'b0} + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MPLR_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q   <= '0;
      mcand_q <= req_i.mcand;
      mplr_q  <= req_i.mplr;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      mplr_q <= {mplr_q[MPLR_W-2:0], 1'b0};
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

@@ rtl/joystick_filter_deadband_pwm.sv @@
// Top level of the two-axis joystick conditioner: low-pass filter, dead band, PWM mapping.
//
// Samples enter on the s_axis channel: tdata carries the ADC sample, tuser selects the
// axis. Every accepted sample produces exactly one transfer on the m_axis channel with
// the truncated filter output, the dead-band zone and all three PWM compare values.
// Registers are written through the cfg channel, which is always ready; write them only
// while no sample is in flight. Writing filter_start reloads both axis filters.
// A new sample can be taken in the cycle after the result of the previous one is registered.
// The pace is set by the single bit-serial multiplier, which runs once for the filter
// update and once for the gain mapping, one multiplier bit per cycle.
// The result sits in an output register, so a new sample is accepted while the
// previous result still waits; if the receiver stalls, the finished result of the
// following sample holds in the block until the output register frees up.
// Reset loads the register defaults, sets both filters to filter_start and clears
// all compare values. Only one sample is processed at a time.
`include "joystick_filter_deadband_pwm_macros.svh"

module joystick_filter_deadband_pwm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [jfdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] sample, rest zero
  input  logic                             s_axis_tuser,  // [0] channel
  // Result channel.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [11:0] filtered, [13:12] zone, [29:14] compare_one, [45:30] compare_two,
  // [61:46] compare_three, [63:62] zero
  output logic [jfdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jfdp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jfdp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import jfdp_pkg::*;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha_q;
  logic [EDGE_W-1:0]  upper_q, lower_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [OUT_W-1:0]   out_min_q, out_max_q;

  // Per-axis filter state and the three compare registers.
  logic [Y_W-1:0]   filt_q [2];
  logic [OUT_W-1:0] comp_q [3];
  logic [OUT_W-1:0] comp_nxt [3];

  // Working registers of the sample in flight.
  logic              ch_q;
  logic [Y_W-1:0]    y_q;
  logic [DIST_W-1:0] f_q;
  zone_e             zone_q;
  logic [OUT_W-1:0]  c_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic in_fire, out_free, cfg_fire;

  logic [ALPHA_W-1:0] a_eff;
  logic [Y_W-1:0]     x_ext, y_cur, y_new;
  logic [D_W-1:0]     diff;
  logic [PROD_W-1:0]  total;
  logic [DIST_W-1:0]  upper_ext, lower_ext, defl;
  zone_e              zone_d;
  logic [SUM_W-1:0]   map_sum;
  logic [OUT_W-1:0]   c_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Weights above one count as one: the output then follows the sample.
  assign a_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

  // Filter update is written as y + a*(x - y) so that one multiply does the job.
  assign x_ext = {s_axis_tdata[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign y_cur = filt_q[s_axis_tuser];
  assign diff  = D_W'(x_ext) - D_W'(y_cur);
  assign total = PROD_W'({y_q, {WEIGHT_SHIFT{1'b0}}}) + mul_rsp.product;
  assign y_new = total[WEIGHT_SHIFT +: Y_W];

  // Dead-band decision; the upper edge is tested first and wins on overlap.
  assign upper_ext = DIST_W'(upper_q);
  assign lower_ext = DIST_W'(lower_q);
  always_comb begin
    if (f_q >= upper_ext) begin
      zone_d = ZONE_ABOVE;
      defl   = f_q - upper_ext;
    end else if (f_q <= lower_ext) begin
      zone_d = ZONE_BELOW;
      defl   = lower_ext - f_q;
    end else begin
      zone_d = ZONE_IN;
      defl   = '0;
    end
  end

  // Mapping: out_min plus the scaled deflection, saturated at out_max without wrap; out_min inside the band.
  assign map_sum = SUM_W'(out_min_q) + SUM_W'(mul_rsp.product[GAIN_SHIFT +: MAP_W]);
  always_comb begin
    if (zone_q == ZONE_IN) begin
      c_d = out_min_q;
    end else if (map_sum > SUM_W'(out_max_q)) begin
      c_d = out_max_q;
    end else begin
      c_d = map_sum[OUT_W-1:0];
    end
  end

  // The multiplier is shared: filter weight first, then the mapping gain.
  always_comb begin
    mul_req.start = in_fire || (state_q == ST_ZONE);
    if (state_q == ST_ZONE) begin
      mul_req.mcand = MCAND_W'(gain_q);
      mul_req.mplr  = MPLR_W'(defl);
    end else begin
      mul_req.mcand = MCAND_W'($signed(diff));
      mul_req.mplr  = MPLR_W'(a_eff);
    end
  end

  jfdp_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Channel 0 steers compare three above the band, compare two below it and both inside it;
  // channel 1 always drives compare one.
  always_comb begin
    comp_nxt = comp_q;
    if (ch_q == 1'b0) begin
      unique case (zone_q)
        ZONE_ABOVE: comp_nxt[2] = c_q;
        ZONE_BELOW: comp_nxt[1] = c_q;
        default: begin
          comp_nxt[1] = c_q;
          comp_nxt[2] = c_q;
        end
      endcase
    end else begin
      comp_nxt[0] = c_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_FILT;
      ST_FILT: if (mul_rsp.done) state_d = ST_UPD;
      ST_UPD:  state_d = ST_ZONE;
      ST_ZONE: state_d = ST_MAP;
      ST_MAP:  if (mul_rsp.done) state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RST;
      upper_q   <= UPPER_RST;
      lower_q   <= LOWER_RST;
      gain_q    <= GAIN_RST;
      out_min_q <= OUT_MIN_RST;
      out_max_q <= OUT_MAX_RST;
      filt_q[0] <= start_to_filter(START_RST);
      filt_q[1] <= start_to_filter(START_RST);
    end else begin
      if (cfg_fire) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_ALPHA:        alpha_q <= cfg_data_i[ALPHA_W-1:0];
          REG_FILTER_START: begin
            filt_q[0] <= start_to_filter(cfg_data_i[EDGE_W-1:0]);
            filt_q[1] <= start_to_filter(cfg_data_i[EDGE_W-1:0]);
          end
          REG_UPPER_EDGE:   upper_q   <= cfg_data_i[EDGE_W-1:0];
          REG_LOWER_EDGE:   lower_q   <= cfg_data_i[EDGE_W-1:0];
          REG_GAIN:         gain_q    <= cfg_data_i[GAIN_W-1:0];
          REG_OUT_MIN:      out_min_q <= cfg_data_i[OUT_W-1:0];
          REG_OUT_MAX:      out_max_q <= cfg_data_i[OUT_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_UPD) begin
        filt_q[ch_q] <= y_new;
      end
    end
  end

  // Compare registers and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q[0]   <= '0;
      comp_q[1]   <= '0;
      comp_q[2]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        comp_q      <= comp_nxt;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the sample in flight.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q <= s_axis_tuser;
      y_q  <= y_cur;
    end
    if (state_q == ST_UPD) begin
      f_q <= DIST_W'(y_new[Y_W-1:FRAC_BITS]);
    end
    if (state_q == ST_ZONE) begin
      zone_q <= zone_d;
    end
    if (state_q == ST_SUM) begin
      c_q <= c_d;
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= OUT_TDATA_W'({comp_nxt[2], comp_nxt[1], comp_nxt[0], zone_q,
                                  f_q[FILT_OUT_W-1:0]});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `JFDP_ASSERT_NEXT(a_accept_starts_mul, clk_i, rst_ni, in_fire, mul_rsp.busy, "multiplier not started by sample")
  `JFDP_ASSERT_IMPL(a_done_when_waiting, clk_i, rst_ni, mul_rsp.done, state_q == ST_FILT || state_q == ST_MAP, "multiplier done outside a wait state")
  `JFDP_ASSERT_IMPL(a_mul_idle_at_out, clk_i, rst_ni, state_q == ST_OUT, !mul_rsp.busy, "multiplier busy while result is issued")
  `JFDP_ASSERT_NEXT(a_map_saturates, clk_i, rst_ni, state_q == ST_SUM, zone_q == ZONE_IN || c_q <= out_max_q, "mapped compare above out_max")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the two-axis joystick conditioner.
`timescale 1ns / 1ps

module tb;
  import jfdp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Extra cycles after the last result, longer than one unstalled sample takes.
  localparam int TAIL_CYCLES = 2 * MPLR_W + 12;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 48;
  // Index that decodes to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [11:0] filtered;
    logic [1:0]  zone;
    logic [15:0] cmp_one;
    logic [15:0] cmp_two;
    logic [15:0] cmp_three;
  } stick_result_t;

  // Tracks the conditioner state, predicts each result and checks the output stream.
  class stick_scoreboard;
    logic [8:0]        alpha_r;
    logic [11:0]       start_r;
    logic [11:0]       upper_r;
    logic [11:0]       lower_r;
    logic [15:0]       gain_r;
    logic [15:0]       min_r;
    logic [15:0]       max_r;
    logic [1:0][19:0]  filt_r;
    logic [2:0][15:0]  cmp_r;
    stick_result_t     expected_q[$];
    int                errors;
    int                checked;
    int                n_in;
    int                n_above;
    int                n_below;

    function new();
      alpha_r = ALPHA_RST;
      start_r = START_RST;
      upper_r = UPPER_RST;
      lower_r = LOWER_RST;
      gain_r  = GAIN_RST;
      min_r   = OUT_MIN_RST;
      max_r   = OUT_MAX_RST;
      cmp_r   = '0;
      errors  = 0;
      checked = 0;
      n_in    = 0;
      n_above = 0;
      n_below = 0;
      reload_filters();
    endfunction

    function void reload_filters();
      filt_r[0] = {start_r, 8'h00};
      filt_r[1] = {start_r, 8'h00};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        REG_ALPHA:        alpha_r = d[8:0];
        REG_FILTER_START: begin
          start_r = d[11:0];
          reload_filters();
        end
        REG_UPPER_EDGE:   upper_r = d[11:0];
        REG_LOWER_EDGE:   lower_r = d[11:0];
        REG_GAIN:         gain_r  = d;
        REG_OUT_MIN:      min_r   = d;
        REG_OUT_MAX:      max_r   = d;
        default: ;
      endcase
    endfunction

    // Distance times Q8.8 gain plus out_min, clamped at out_max without wrap.
    function logic [15:0] scale_deflection(logic [11:0] span);
      logic [31:0] prod;
      logic [31:0] sum;
      prod = 32'(gain_r) * 32'(span);
      sum  = 32'(min_r) + (prod >> 8);
      return (sum > 32'(max_r)) ? max_r : sum[15:0];
    endfunction

    function void note_sample(bit ch, logic [11:0] x);
      logic [8:0]    a;
      logic [31:0]   acc;
      logic [19:0]   y;
      logic [11:0]   f;
      zone_e         z;
      stick_result_t r;
      a   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
      acc = 32'(a) * 32'({x, 8'h00}) + 32'(ALPHA_ONE - a) * 32'(filt_r[ch]);
      y   = acc[27:8];
      filt_r[ch] = y;
      f = y[19:8];
      // The upper edge is tested first, so it wins when the edges overlap.
      if (f >= upper_r) begin
        z = ZONE_ABOVE;
        n_above++;
        if (ch == 1'b0) cmp_r[2] = scale_deflection(f - upper_r);
        else cmp_r[0] = scale_deflection(f - upper_r);
      end else if (f <= lower_r) begin
        z = ZONE_BELOW;
        n_below++;
        if (ch == 1'b0) cmp_r[1] = scale_deflection(lower_r - f);
        else cmp_r[0] = scale_deflection(lower_r - f);
      end else begin
        z = ZONE_IN;
        n_in++;
        if (ch == 1'b0) begin
          cmp_r[1] = min_r;
          cmp_r[2] = min_r;
        end else begin
          cmp_r[0] = min_r;
        end
      end
      r.filtered  = f;
      r.zone      = z;
      r.cmp_one   = cmp_r[0];
      r.cmp_two   = cmp_r[1];
      r.cmp_three = cmp_r[2];
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 20)
        $display("mismatch in result %0d, %0s: got %0d, expected %0d",
                 checked, what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] d);
      stick_result_t w;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", d[15:0], 16'd0);
      end else begin
        w = expected_q.pop_front();
        if (d[11:0] !== w.filtered)
          report("filtered", 16'(d[11:0]), 16'(w.filtered));
        if (d[13:12] !== w.zone)
          report("zone", 16'(d[13:12]), 16'(w.zone));
        if (d[29:14] !== w.cmp_one)   report("compare_one", d[29:14], w.cmp_one);
        if (d[45:30] !== w.cmp_two)   report("compare_two", d[45:30], w.cmp_two);
        if (d[61:46] !== w.cmp_three) report("compare_three", d[61:46], w.cmp_three);
        if (d[63:62] !== 2'b00)
          report("padding", 16'(d[63:62]), 16'd0);
      end
      checked++;
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  stick_scoreboard sb = new();
  int  cycles = 0;
  int  settings = 0;
  bit  steady = 1'b1;
  bit  pressure_done = 1'b0;

  joystick_filter_deadband_pwm uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.expected_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Result side: checks every transfer and throttles tready.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      // One long hold-off while samples keep coming, so the block backs up.
      if (!pressure_done && sb.checked >= 250) begin
        pressure_done = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Leaves the write channel valid; the caller lowers it after the last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, d);
  endtask

  // Leaves tvalid high so back-to-back samples need no extra assignment.
  task automatic send_sample(bit ch, logic [11:0] x);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(x);
    s_axis_tuser  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(ch, x);
  endtask

  task automatic sender_gap();
    int gap;
    gap = 0;
    if (!steady)
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every predicted result has been transferred; registers may then change.
  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    settings++;
  endtask

  function automatic logic [11:0] pick_sample();
    logic [11:0] e;
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      2: begin
        e = ($urandom_range(0, 1) == 1) ? sb.upper_r : sb.lower_r;
        return 12'($urandom_range((e < 12'd4) ? 0 : e - 4, (e > 12'd4091) ? 4095 : e + 4));
      end
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic [11:0] centre;
    logic [11:0] half;
    logic [15:0] lo;
    if ($urandom_range(0, 1) == 0 || settings < 4) begin
      case ($urandom_range(0, 7))
        0: cfg_write(REG_ALPHA, 16'd0);
        1: cfg_write(REG_ALPHA, 16'd256);
        2: cfg_write(REG_ALPHA, 16'($urandom_range(257, 65535)));
        default: cfg_write(REG_ALPHA, 16'($urandom_range(1, 255)));
      endcase
    end
    if ($urandom_range(0, 2) == 0) cfg_write(REG_FILTER_START, 16'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      // Arbitrary edges, overlapping ones included.
      cfg_write(REG_UPPER_EDGE, 16'($urandom));
      cfg_write(REG_LOWER_EDGE, 16'($urandom));
    end else begin
      centre = 12'($urandom_range(200, 3900));
      half   = 12'($urandom_range(0, 600));
      cfg_write(REG_UPPER_EDGE, (centre > 12'd4095 - half) ? 16'd4095 : 16'(centre + half));
      cfg_write(REG_LOWER_EDGE, (centre < half) ? 16'd0 : 16'(centre - half));
    end
    if ($urandom_range(0, 1) == 0)
      cfg_write(REG_GAIN, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2048)));
    if ($urandom_range(0, 1) == 0) begin
      lo = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      cfg_write(REG_OUT_MIN, lo);
      cfg_write(REG_OUT_MAX, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(lo, 65535)));
    end
    if ($urandom_range(0, 4) == 0) cfg_write(REG_NONE, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: slow filter pulled to both ends from mid scale.
    send_sample(1'b0, 12'hFFF);
    send_sample(1'b1, 12'h000);
    send_sample(1'b0, 12'd2048);
    send_sample(1'b1, 12'd2048);
    s_axis_tvalid <= 1'b0;
    drain();

    // Filter follows the sample; saturation at the top, edges hit exactly.
    cfg_write(REG_ALPHA, 16'd256);
    cfg_write(REG_FILTER_START, 16'd0);
    cfg_write(REG_UPPER_EDGE, 16'd3000);
    cfg_write(REG_LOWER_EDGE, 16'd1000);
    cfg_write(REG_GAIN, 16'hFFFF);
    cfg_write(REG_OUT_MIN, 16'd100);
    cfg_write(REG_OUT_MAX, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_sample(1'b0, 12'hFFF);
    send_sample(1'b0, 12'h000);
    send_sample(1'b0, 12'd2000);
    send_sample(1'b1, 12'd3000);
    send_sample(1'b1, 12'd1000);
    send_sample(1'b1, 12'd1500);
    s_axis_tvalid <= 1'b0;
    drain();

    // Alpha beyond one, overlapping edges, out_min above out_max, zero gain,
    // and a write to an index that decodes to nothing.
    cfg_write(REG_ALPHA, 16'd511);
    cfg_write(REG_UPPER_EDGE, 16'd1000);
    cfg_write(REG_LOWER_EDGE, 16'd3000);
    cfg_write(REG_OUT_MIN, 16'd5000);
    cfg_write(REG_OUT_MAX, 16'd3000);
    cfg_write(REG_GAIN, 16'd0);
    cfg_write(REG_NONE, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_sample(1'b0, 12'd2000);
    send_sample(1'b1, 12'd500);
    send_sample(1'b0, 12'd4000);
    send_sample(1'b1, 12'hFFF);
    s_axis_tvalid <= 1'b0;
    drain();

    // Zero alpha freezes both filters at a freshly loaded full-scale start value.
    cfg_write(REG_ALPHA, 16'd0);
    cfg_write(REG_FILTER_START, 16'hFFFF);
    cfg_write(REG_GAIN, 16'd1);
    cfg_valid_i <= 1'b0;
    send_sample(1'b0, 12'h000);
    send_sample(1'b1, 12'h000);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p % 3 == 0);
      random_settings();
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        send_sample(1'($urandom), pick_sample());
        if (k == PHASE_SAMPLES - 1) s_axis_tvalid <= 1'b0;
        else sender_gap();
      end
      drain();
    end

    // Anything arriving now has no matching sample and is flagged by the sink.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d results over %0d register settings in %0d cycles",
             sb.checked, settings, cycles);
    $display("zones seen: %0d inside, %0d above, %0d below; %0d mismatches",
             sb.n_in, sb.n_above, sb.n_below, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ joystick_filter_deadband_pwm.f @@
+incdir+rtl
rtl/jfdp_pkg.sv
rtl/jfdp_serial_mul.sv
rtl/joystick_filter_deadband_pwm.sv
tb/sv/tb.sv
